// ===== rtl/hsvrgb_pkg.sv =====
// Shared constants and helpers for the HSV to RGB pixel converter.
// Standalone package; used by hsv_to_rgb_converter_core.
`timescale 1ns / 1ps

package hsvrgb_pkg;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int FRAC_W  = 16;
    localparam int SEC_W   = 3;
    localparam int PROD_W  = LEVEL_W + FRAC_W;       // s*f and the q/t numerators
    localparam int WIDE_W  = LEVEL_W + PROD_W;       // v times a numerator
    localparam int MID_W   = 2 * LEVEL_W;            // v*(255-s) and the scaled-down products

    localparam int IN_TDATA_W  = HUE_W + 2 * LEVEL_W;
    localparam int OUT_TDATA_W = 3 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
    // 255 * 65536: full level in the fraction scale
    localparam logic [PROD_W-1:0]  FULL_SCALED = {FULL_LEVEL, {FRAC_W{1'b0}}};

    // Color wheel sectors, one sixth of a turn each
    localparam logic [SEC_W-1:0] SEC_RED_YELLOW     = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN   = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN_CYAN     = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN_BLUE      = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA   = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAGENTA_RED    = 3'd5;

    // Floor division by 255 for x <= 255*255.
    // Estimate by x*(1+1/256)/256, which is low by at most one, then correct.
    function automatic logic [LEVEL_W-1:0] div255(input logic [MID_W-1:0] x);
        logic [MID_W:0]   est_sum;
        logic [LEVEL_W:0] est;
        logic [MID_W:0]   rem;
        est_sum = {1'b0, x} + {{(LEVEL_W + 1){1'b0}}, x[MID_W-1:LEVEL_W]};
        est     = est_sum[MID_W:LEVEL_W];
        rem     = {1'b0, x} - (({{LEVEL_W{1'b0}}, est} << LEVEL_W)
                                - {{LEVEL_W{1'b0}}, est});
        if (rem >= {{(LEVEL_W + 1){1'b0}}, FULL_LEVEL}) begin
            est = est + {{LEVEL_W{1'b0}}, 1'b1};
        end
        return est[LEVEL_W-1:0];
    endfunction

endpackage

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// Channel  | dir | tdata fields (low bit up)                      | handshake
// s_       | in  | hue[15:0], saturation[23:16], brightness[31:24] | s_tvalid/s_tready
// m_       | out | red[7:0], green[15:8], blue[23:16]              | m_tvalid/m_tready
//
// Four register stages; one pixel enters per clock while s_tready is high. Stage 1
// scales the hue and forms v*(255-s), stage 2 forms s*f and the divide for p,
// stage 3 the two v-products, stage 4 the divides for q and t and the sector
// select. Each stage holds when the one after it is full and stalled, so s_tready
// falls only when all four stages hold data and m_tready is low.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]    s_tdata,   // hue, saturation, brightness
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hsvrgb_pkg::OUT_TDATA_W-1:0]   m_tdata    // red, green, blue
);

    localparam int LW = hsvrgb_pkg::LEVEL_W;
    localparam int FW = hsvrgb_pkg::FRAC_W;
    localparam int SW = hsvrgb_pkg::SEC_W;
    localparam int PW = hsvrgb_pkg::PROD_W;
    localparam int WW = hsvrgb_pkg::WIDE_W;
    localparam int MW = hsvrgb_pkg::MID_W;
    localparam int HW = hsvrgb_pkg::HUE_W;

    // Stage valid bits and advance enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    assign en4      = !s4_valid_reg || m_tready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg <= s_tvalid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- Stage 1: hue*6 split, v*(255-s) ----------------
    logic [HW-1:0]   in_hue;
    logic [LW-1:0]   in_sat, in_bright;
    logic [HW+2:0]   hue6;
    logic [SW-1:0]   sec1_next, sec1_reg;
    logic [FW-1:0]   frac1_next, frac1_reg;
    logic [LW-1:0]   sat1_reg, bright1_reg;
    logic [MW-1:0]   pnum1_next, pnum1_reg;

    assign in_hue    = s_tdata[HW-1:0];
    assign in_sat    = s_tdata[HW+LW-1:HW];
    assign in_bright = s_tdata[HW+2*LW-1:HW+LW];

    assign hue6       = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};
    assign sec1_next  = hue6[HW+2:FW];
    assign frac1_next = hue6[FW-1:0];
    assign pnum1_next = MW'(in_bright) * MW'(hsvrgb_pkg::FULL_LEVEL - in_sat);

    always_ff @(posedge aclk) begin
        if (en1) begin
            sec1_reg    <= sec1_next;
            frac1_reg   <= frac1_next;
            sat1_reg    <= in_sat;
            bright1_reg <= in_bright;
            pnum1_reg   <= pnum1_next;
        end
    end

    // ---------------- Stage 2: s*f, numerators, p ----------------
    logic [PW-1:0]   sf2;
    logic [PW-1:0]   qnum2_next, qnum2_reg;
    logic [PW-1:0]   tnum2_next, tnum2_reg;
    logic [LW-1:0]   p2_next, p2_reg;
    logic [SW-1:0]   sec2_reg;
    logic [LW-1:0]   bright2_reg;

    assign sf2        = PW'(sat1_reg) * PW'(frac1_reg);
    // q numerator: 255*65536 - s*f; t numerator: (255-s)*65536 + s*f
    assign qnum2_next = hsvrgb_pkg::FULL_SCALED - sf2;
    assign tnum2_next = {hsvrgb_pkg::FULL_LEVEL - sat1_reg, {FW{1'b0}}} + sf2;
    assign p2_next    = hsvrgb_pkg::div255(pnum1_reg);

    always_ff @(posedge aclk) begin
        if (en2) begin
            qnum2_reg   <= qnum2_next;
            tnum2_reg   <= tnum2_next;
            p2_reg      <= p2_next;
            sec2_reg    <= sec1_reg;
            bright2_reg <= bright1_reg;
        end
    end

    // ---------------- Stage 3: v times numerators, drop fraction ----------------
    logic [WW-1:0]   qprod3, tprod3;
    logic [MW-1:0]   qmid3_reg, tmid3_reg;
    logic [LW-1:0]   p3_reg, bright3_reg;
    logic [SW-1:0]   sec3_reg;

    assign qprod3 = WW'(bright2_reg) * WW'(qnum2_reg);
    assign tprod3 = WW'(bright2_reg) * WW'(tnum2_reg);

    always_ff @(posedge aclk) begin
        if (en3) begin
            qmid3_reg   <= qprod3[WW-1:FW];
            tmid3_reg   <= tprod3[WW-1:FW];
            p3_reg      <= p2_reg;
            bright3_reg <= bright2_reg;
            sec3_reg    <= sec2_reg;
        end
    end

    // ---------------- Stage 4: q, t and sector select ----------------
    logic [LW-1:0] q4, t4;
    logic [LW-1:0] red_next, green_next, blue_next;
    logic [LW-1:0] red_reg, green_reg, blue_reg;

    assign q4 = hsvrgb_pkg::div255(qmid3_reg);
    assign t4 = hsvrgb_pkg::div255(tmid3_reg);

    always_comb begin
        case (sec3_reg)
            hsvrgb_pkg::SEC_RED_YELLOW: begin
                red_next = bright3_reg; green_next = t4;          blue_next = p3_reg;
            end
            hsvrgb_pkg::SEC_YELLOW_GREEN: begin
                red_next = q4;          green_next = bright3_reg; blue_next = p3_reg;
            end
            hsvrgb_pkg::SEC_GREEN_CYAN: begin
                red_next = p3_reg;      green_next = bright3_reg; blue_next = t4;
            end
            hsvrgb_pkg::SEC_CYAN_BLUE: begin
                red_next = p3_reg;      green_next = q4;          blue_next = bright3_reg;
            end
            hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
                red_next = t4;          green_next = p3_reg;      blue_next = bright3_reg;
            end
            hsvrgb_pkg::SEC_MAGENTA_RED: begin
                red_next = bright3_reg; green_next = p3_reg;      blue_next = q4;
            end
            default: begin
                red_next = bright3_reg; green_next = p3_reg;      blue_next = q4;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = s4_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    // ---------------- Assertions ----------------
    // A transfer reaches the output when nothing stalls
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready |=> ##1 m_tvalid)
        else $error("pixel did not reach output on an unstalled pipeline");

    // Input backpressure only when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                       && s4_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    // The p, q and t levels never exceed brightness
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (q4 <= bright3_reg && t4 <= bright3_reg
                          && p3_reg <= bright3_reg))
        else $error("color level above brightness");

endmodule
